// ===== hw/rtl/sit_pkg.sv =====
// Shared types and constants for the segment intersection test pipeline.
// No dependencies; used by sit_sign and segment_intersection_test_core.
package sit_pkg;

    // Four cross products: A's line against B start / B end,
    // then B's line against A start / A end.
    localparam int NUM_CROSS   = 4;
    localparam int OUT_TDATA_W = 8;

    // Per-cross-product flags handed from the sign stage to the output stage
    typedef struct packed {
        logic                 box;
        logic [NUM_CROSS-1:0] neg;
        logic [NUM_CROSS-1:0] zero;
    } t_sign_flags;

endpackage

// ===== hw/rtl/sit_diff.sv =====
// Stage 1: unpacks the eight coordinates, forms the coordinate differences
// and the bounding-box overlap test. No package dependency.
module sit_diff #(
    parameter int COORD_BITS = 16,
    localparam int DW = COORD_BITS + 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [8*COORD_BITS-1:0] i_data,
    output logic                    o_valid,
    output logic                    o_box,
    output logic signed [DW-1:0]    o_dx [2],
    output logic signed [DW-1:0]    o_dy [2],
    output logic signed [DW-1:0]    o_qx [4],
    output logic signed [DW-1:0]    o_qy [4]
);

    logic signed [COORD_BITS-1:0] crd [8];
    logic                         r_valid;
    logic                         r_box, n_box;
    logic signed [DW-1:0]         r_dx [2], n_dx [2];
    logic signed [DW-1:0]         r_dy [2], n_dy [2];
    logic signed [DW-1:0]         r_qx [4], n_qx [4];
    logic signed [DW-1:0]         r_qy [4], n_qy [4];

    // Field order: ax0, ay0, ax1, ay1, bx0, by0, bx1, by1
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            crd[k] = i_data[k*COORD_BITS +: COORD_BITS];
        end
    end

    // Differences, one bit wider than a coordinate so they never wrap
    always_comb begin
        for (int s = 0; s < 2; s++) begin
            n_dx[s] = DW'(crd[4*s+2]) - DW'(crd[4*s]);
            n_dy[s] = DW'(crd[4*s+3]) - DW'(crd[4*s+1]);
        end
        for (int k = 0; k < 4; k++) begin
            // line k>>1, point k&1 of the other segment
            n_qx[k] = DW'(crd[4*(1-(k/2)) + 2*(k%2)])     - DW'(crd[4*(k/2)]);
            n_qy[k] = DW'(crd[4*(1-(k/2)) + 2*(k%2) + 1]) - DW'(crd[4*(k/2)+1]);
        end
    end

    // Box overlap per axis: min(a) <= max(b) and max(a) >= min(b),
    // written as pairwise compares so they run in parallel
    always_comb begin
        logic lo_x, hi_x, lo_y, hi_y;
        lo_x = 1'b0;
        hi_x = 1'b0;
        lo_y = 1'b0;
        hi_y = 1'b0;
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) begin
                lo_x |= (crd[2*i]   <= crd[4+2*j]);
                hi_x |= (crd[2*i]   >= crd[4+2*j]);
                lo_y |= (crd[2*i+1] <= crd[4+2*j+1]);
                hi_y |= (crd[2*i+1] >= crd[4+2*j+1]);
            end
        end
        n_box = lo_x & hi_x & lo_y & hi_y;
    end

    // Valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_box <= n_box;
            r_dx  <= n_dx;
            r_dy  <= n_dy;
            r_qx  <= n_qx;
            r_qy  <= n_qy;
        end
    end

    assign o_valid = r_valid;
    assign o_box   = r_box;
    assign o_dx    = r_dx;
    assign o_dy    = r_dy;
    assign o_qx    = r_qx;
    assign o_qy    = r_qy;

endmodule

// ===== hw/rtl/sit_mult.sv =====
// Stage 2: the eight signed products of the four cross products.
// Fed by sit_diff; no package dependency.
module sit_mult #(
    parameter int COORD_BITS = 16,
    localparam int DW = COORD_BITS + 1,
    localparam int PW = 2 * DW
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic                 i_box,
    input  logic signed [DW-1:0] i_dx [2],
    input  logic signed [DW-1:0] i_dy [2],
    input  logic signed [DW-1:0] i_qx [4],
    input  logic signed [DW-1:0] i_qy [4],
    output logic                 o_valid,
    output logic                 o_box,
    output logic signed [PW-1:0] o_pa [4],
    output logic signed [PW-1:0] o_pb [4]
);

    logic                 r_valid;
    logic                 r_box;
    logic signed [PW-1:0] r_pa [4], n_pa [4];
    logic signed [PW-1:0] r_pb [4], n_pb [4];

    // cross = dx*qy - qx*dy; the subtraction happens in the next stage
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_pa[k] = PW'(i_dx[k/2]) * PW'(i_qy[k]);
            n_pb[k] = PW'(i_qx[k])   * PW'(i_dy[k/2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_box <= i_box;
            r_pa  <= n_pa;
            r_pb  <= n_pb;
        end
    end

    assign o_valid = r_valid;
    assign o_box   = r_box;
    assign o_pa    = r_pa;
    assign o_pb    = r_pb;

endmodule

// ===== hw/rtl/sit_sign.sv =====
// Stage 3: finishes each cross product and keeps only its sign and zero flags.
// Fed by sit_mult; uses sit_pkg for the flag struct.
module sit_sign #(
    parameter int COORD_BITS = 16,
    localparam int PW = 2 * (COORD_BITS + 1),
    localparam int CW = PW + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic                 i_box,
    input  logic signed [PW-1:0] i_pa [4],
    input  logic signed [PW-1:0] i_pb [4],
    output logic                 o_valid,
    output sit_pkg::t_sign_flags o_flags
);

    logic                 r_valid;
    sit_pkg::t_sign_flags r_flags, n_flags;
    logic signed [CW-1:0] xprod [4];

    // Exact cross product, one bit wider than the products
    always_comb begin
        n_flags.box = i_box;
        for (int k = 0; k < sit_pkg::NUM_CROSS; k++) begin
            xprod[k]        = CW'(i_pa[k]) - CW'(i_pb[k]);
            n_flags.neg[k]  = xprod[k][CW-1];
            n_flags.zero[k] = (xprod[k] == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flags <= n_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_flags = r_flags;

endmodule

// ===== hw/rtl/segment_intersection_test_core.sv =====
// Top level of the segment intersection test: four pipeline stages and the
// stream handshake. Depends on sit_pkg, sit_diff, sit_mult and sit_sign.
//
// Takes one request (two segments, four signed endpoints) per clock and
// returns one result per request, in order: o_m_tdata[0] is 1 when the
// closed segments touch or cross. A request passes through the difference
// and box-test, product, cross-product sign and output registers before its
// result is valid; the multiply stage sets the clock limit. Throughput
// is one request per cycle while the output side takes results; each stage
// holds its item under back-pressure and fills any bubble ahead of it.
module segment_intersection_test_core #(
    parameter int COORD_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y,
    // b_end_x, b_end_y (lowest first), COORD_BITS each, signed
    input  logic [8*COORD_BITS-1:0]         i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // segments_meet in bit 0, upper bits zero
    output logic [sit_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    logic                 rdy1, rdy2, rdy3, rdy_out;
    logic                 v1, v2, v3;
    logic                 box1, box2;
    logic signed [DW-1:0] dx [2];
    logic signed [DW-1:0] dy [2];
    logic signed [DW-1:0] qx [4];
    logic signed [DW-1:0] qy [4];
    logic signed [PW-1:0] pa [4];
    logic signed [PW-1:0] pb [4];
    sit_pkg::t_sign_flags flags;
    logic                 r_out_valid;
    logic                 r_meet, n_meet;

    // Stall chain: a stage advances when it is empty or its successor advances
    assign rdy_out    = !r_out_valid || i_m_tready;
    assign rdy3       = !v3 || rdy_out;
    assign rdy2       = !v2 || rdy3;
    assign rdy1       = !v1 || rdy2;
    assign o_s_tready = rdy1;

    sit_diff #(.COORD_BITS(COORD_BITS)) u_diff (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (rdy1),
        .i_valid (i_s_tvalid),
        .i_data  (i_s_tdata),
        .o_valid (v1),
        .o_box   (box1),
        .o_dx    (dx),
        .o_dy    (dy),
        .o_qx    (qx),
        .o_qy    (qy)
    );

    sit_mult #(.COORD_BITS(COORD_BITS)) u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (rdy2),
        .i_valid (v1),
        .i_box   (box1),
        .i_dx    (dx),
        .i_dy    (dy),
        .i_qx    (qx),
        .i_qy    (qy),
        .o_valid (v2),
        .o_box   (box2),
        .o_pa    (pa),
        .o_pb    (pb)
    );

    sit_sign #(.COORD_BITS(COORD_BITS)) u_sign (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (rdy3),
        .i_valid (v2),
        .i_box   (box2),
        .i_pa    (pa),
        .i_pb    (pb),
        .o_valid (v3),
        .o_flags (flags)
    );

    // Each line test passes on a zero cross product or a sign change
    always_comb begin
        logic line_a, line_b;
        line_a = flags.zero[0] || flags.zero[1] || (flags.neg[0] != flags.neg[1]);
        line_b = flags.zero[2] || flags.zero[3] || (flags.neg[2] != flags.neg[3]);
        n_meet = flags.box && line_a && line_b;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rdy_out) begin
            r_out_valid <= v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_out) begin
            r_meet <= n_meet;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(sit_pkg::OUT_TDATA_W-1){1'b0}}, r_meet};

    // Input side only blocks when the whole pipe is full and the output stalls
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (v1 && v2 && v3 && o_m_tvalid && !i_m_tready))
        else $error("input stalled while the pipeline has room");

    // An accepted request lands in the first stage
    a_accept_enters_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> v1)
        else $error("accepted request lost at stage 1");

    // A stalled item in the last stage is kept
    a_stage3_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v3 && !rdy_out) |=> v3)
        else $error("stage 3 item dropped under back-pressure");

endmodule
